// ===== sv/tgr_pkg.sv =====
// Shared types, constants and register map of the gesture recognizer.
`default_nettype none
package tgr_pkg;

	localparam int TIME_W = 32;
	localparam int DIST_W = 13;
	localparam int MS_W = 16;
	localparam int JDG_W = DIST_W + 1;

	localparam logic [DIST_W-1:0] FILT_EMPTY = DIST_W'((1 << DIST_W) - 2);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W = CFG_IDX_W + 2;
	localparam int DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAVE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 3'd7;

	localparam logic [DIST_W-1:0] RST_VALID_MIN = 13'd40;
	localparam logic [DIST_W-1:0] RST_VALID_MAX = 13'd1200;
	localparam logic [DIST_W-1:0] RST_ENTER = 13'd180;
	localparam logic [DIST_W-1:0] RST_LEAVE = 13'd280;
	localparam logic [MS_W-1:0] RST_WAVE_MIN = 16'd80;
	localparam logic [MS_W-1:0] RST_WAVE_MAX = 16'd520;
	localparam logic [MS_W-1:0] RST_HOLD = 16'd750;
	localparam logic [MS_W-1:0] RST_DOUBLE = 16'd650;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_NEAR = 3'd1,
		EV_FAR = 3'd2,
		EV_WAVE = 3'd3,
		EV_DOUBLE = 3'd4,
		EV_HOLD_START = 3'd5,
		EV_HOLDING = 3'd6,
		EV_HOLD_END = 3'd7
	} event_t;

	typedef struct packed {
		logic [DIST_W-1:0] valid_min_mm;
		logic [DIST_W-1:0] valid_max_mm;
		logic [DIST_W-1:0] enter_mm;
		logic [DIST_W-1:0] leave_mm;
		logic [MS_W-1:0] wave_min_ms;
		logic [MS_W-1:0] wave_max_ms;
		logic [MS_W-1:0] hold_ms;
		logic [MS_W-1:0] double_ms;
	} cfg_t;

	// One classified request: judged distance, filter value after it, timestamp.
	typedef struct packed {
		logic [JDG_W-1:0] judged_mm;
		logic [DIST_W-1:0] smoothed_mm;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

// ===== sv/tgr_front.sv =====
// Front end: takes samples, checks the valid window and runs the smoothing filter.
`default_nettype none
module tgr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire tgr_pkg::cfg_t cfg,
	input wire logic push,
	input wire logic q_full,
	input wire logic [tgr_pkg::DIST_W-1:0] distance_mm,
	input wire logic [tgr_pkg::TIME_W-1:0] now_ms,
	output logic q_wr,
	output tgr_pkg::item_t q_item
);

	logic [tgr_pkg::DIST_W-1:0] filt_q;
	logic [tgr_pkg::DIST_W+1:0] sum3;
	logic [tgr_pkg::DIST_W-1:0] filt_next;
	logic in_window;

	assign q_wr = push & ~q_full;
	assign in_window = (distance_mm >= cfg.valid_min_mm) && (distance_mm <= cfg.valid_max_mm);

	// Three parts old value plus one part new sample, truncated by the shift.
	assign sum3 = ({2'b00, filt_q} << 1) + {2'b00, filt_q} + {2'b00, distance_mm};

	always_comb begin
		if (!in_window) begin
			filt_next = filt_q;
		end else if (filt_q == tgr_pkg::FILT_EMPTY) begin
			filt_next = distance_mm;
		end else begin
			filt_next = sum3[tgr_pkg::DIST_W+1:2];
		end
	end

	always_comb begin
		q_item.smoothed_mm = filt_next;
		q_item.now_ms = now_ms;
		if (in_window) begin
			q_item.judged_mm = {1'b0, filt_next};
		end else begin
			q_item.judged_mm = {1'b0, cfg.valid_max_mm} + tgr_pkg::JDG_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= tgr_pkg::FILT_EMPTY;
		end else if (q_wr) begin
			filt_q <= filt_next;
		end
	end

endmodule
`default_nettype wire

// ===== sv/tgr_fifo.sv =====
// Short queue of classified samples between the front end and the gesture machine.
`default_nettype none
module tgr_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire tgr_pkg::item_t wr_item,
	input wire logic rd,
	output tgr_pkg::item_t rd_item,
	output tgr_pkg::qstat_t stat
);

	tgr_pkg::item_t store_q [tgr_pkg::QDEPTH];
	logic [tgr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tgr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tgr_pkg::QPTR_W:0] count_q;
	logic do_wr;
	logic do_rd;

	assign stat.full = (count_q == (tgr_pkg::QPTR_W+1)'(tgr_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr = wr & ~stat.full;
	assign do_rd = rd & ~stat.empty;
	assign rd_item = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tgr_back.sv =====
// Back end: idle/near/holding gesture machine and the result register.
`default_nettype none
module tgr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire tgr_pkg::cfg_t cfg,
	input wire tgr_pkg::item_t item,
	input wire tgr_pkg::qstat_t qstat,
	output logic q_rd,
	input wire logic pop,
	output logic out_valid,
	output logic [2:0] gesture_event,
	output logic [tgr_pkg::DIST_W-1:0] smoothed_mm,
	output logic hand_near
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_NEAR = 2'd1,
		PH_HOLD = 2'd2
	} phase_t;

	localparam int PAD_W = tgr_pkg::TIME_W - tgr_pkg::MS_W;

	phase_t phase_q, phase_n;
	logic [tgr_pkg::TIME_W-1:0] near_start_q, near_start_n;
	logic [tgr_pkg::TIME_W-1:0] last_wave_q, last_wave_n;
	logic hold_flag_q, hold_flag_n;
	tgr_pkg::event_t ev_q, ev_n;
	logic [tgr_pkg::DIST_W-1:0] smoothed_q;
	logic near_q;
	logic valid_q;
	logic [tgr_pkg::TIME_W-1:0] held;
	logic [tgr_pkg::TIME_W-1:0] since_wave;
	logic is_close;
	logic is_gone;
	logic in_wave;

	// A request moves on when the result register is free or is being emptied.
	assign q_rd = ~qstat.empty & (~valid_q | pop);

	assign held = item.now_ms - near_start_q;
	assign since_wave = item.now_ms - last_wave_q;
	assign is_close = item.judged_mm < {1'b0, cfg.enter_mm};
	assign is_gone = item.judged_mm > {1'b0, cfg.leave_mm};
	assign in_wave = (held >= {{PAD_W{1'b0}}, cfg.wave_min_ms})
		&& (held <= {{PAD_W{1'b0}}, cfg.wave_max_ms});

	always_comb begin
		phase_n = phase_q;
		near_start_n = near_start_q;
		last_wave_n = last_wave_q;
		hold_flag_n = hold_flag_q;
		ev_n = tgr_pkg::EV_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (is_close) begin
					phase_n = PH_NEAR;
					near_start_n = item.now_ms;
					hold_flag_n = 1'b0;
					ev_n = tgr_pkg::EV_NEAR;
				end
			end
			PH_NEAR: begin
				if (is_gone) begin
					phase_n = PH_IDLE;
					if (!in_wave) begin
						ev_n = tgr_pkg::EV_FAR;
					end else if (since_wave <= {{PAD_W{1'b0}}, cfg.double_ms}) begin
						// A second wave consumes the first, so a third starts fresh.
						last_wave_n = '0;
						ev_n = tgr_pkg::EV_DOUBLE;
					end else begin
						last_wave_n = item.now_ms;
						ev_n = tgr_pkg::EV_WAVE;
					end
				end else if (held >= {{PAD_W{1'b0}}, cfg.hold_ms}) begin
					phase_n = PH_HOLD;
					hold_flag_n = 1'b1;
					ev_n = tgr_pkg::EV_HOLD_START;
				end
			end
			PH_HOLD: begin
				if (is_gone) begin
					phase_n = PH_IDLE;
					hold_flag_n = 1'b0;
					ev_n = tgr_pkg::EV_HOLD_END;
				end else if (hold_flag_q) begin
					ev_n = tgr_pkg::EV_HOLDING;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			near_start_q <= '0;
			last_wave_q <= '0;
			hold_flag_q <= 1'b0;
			ev_q <= tgr_pkg::EV_NONE;
			smoothed_q <= tgr_pkg::FILT_EMPTY;
			near_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				phase_q <= phase_n;
				near_start_q <= near_start_n;
				last_wave_q <= last_wave_n;
				hold_flag_q <= hold_flag_n;
				ev_q <= ev_n;
				smoothed_q <= item.smoothed_mm;
				near_q <= (phase_n == PH_NEAR) || (phase_n == PH_HOLD);
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign gesture_event = ev_q;
	assign smoothed_mm = smoothed_q;
	assign hand_near = near_q;

endmodule
`default_nettype wire

// ===== sv/tof_gesture_recognizer_unit.sv =====
// Top level of the time-of-flight gesture recognizer with its register port.
//
//   Channel  Handshake           Payload
//   ------   ------------------  ------------------------------------------
//   input    push / full         distance_mm[12:0], now_ms[31:0]
//   result   pop / empty         gesture_event[2:0], smoothed_mm[12:0], hand_near
//   config   psel/penable/pwrite paddr[4:0], pwdata[31:0], prdata[31:0], pready
//
// One request is accepted per clock while full is low, and one result leaves per clock
// while pop is held and results are waiting. The edge that accepts a request writes it
// into the four-entry queue; the gesture machine then loads the result register once it
// is free or is being popped. Filter and gesture machine both register a combinational next state.
// full rises only when the queue holds four requests; the front end stalls on its own.
// Reset clears the filter to its empty mark, the machine to idle, the queue and the result register.
`default_nettype none
module tof_gesture_recognizer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tgr_pkg::ADDR_W-1:0] paddr,
	input wire logic [tgr_pkg::DATA_W-1:0] pwdata,
	output logic [tgr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input wire logic push,
	output logic full,
	input wire logic [tgr_pkg::DIST_W-1:0] distance_mm,
	input wire logic [tgr_pkg::TIME_W-1:0] now_ms,
	output logic empty,
	input wire logic pop,
	output logic [2:0] gesture_event,
	output logic [tgr_pkg::DIST_W-1:0] smoothed_mm,
	output logic hand_near
);

	localparam int DPAD = tgr_pkg::DATA_W - tgr_pkg::DIST_W;
	localparam int MPAD = tgr_pkg::DATA_W - tgr_pkg::MS_W;

	tgr_pkg::cfg_t cfg_q;
	logic [tgr_pkg::CFG_IDX_W-1:0] reg_idx;
	logic reg_wr;

	tgr_pkg::item_t front_item;
	tgr_pkg::item_t head_item;
	tgr_pkg::qstat_t qstat;
	logic q_wr;
	logic q_rd;
	logic out_valid;

	// Register port: every access completes without wait states.
	assign pready = 1'b1;
	assign reg_idx = paddr[tgr_pkg::ADDR_W-1:2];
	assign reg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_min_mm <= tgr_pkg::RST_VALID_MIN;
			cfg_q.valid_max_mm <= tgr_pkg::RST_VALID_MAX;
			cfg_q.enter_mm <= tgr_pkg::RST_ENTER;
			cfg_q.leave_mm <= tgr_pkg::RST_LEAVE;
			cfg_q.wave_min_ms <= tgr_pkg::RST_WAVE_MIN;
			cfg_q.wave_max_ms <= tgr_pkg::RST_WAVE_MAX;
			cfg_q.hold_ms <= tgr_pkg::RST_HOLD;
			cfg_q.double_ms <= tgr_pkg::RST_DOUBLE;
		end else if (reg_wr) begin
			case (reg_idx)
				tgr_pkg::REG_VALID_MIN: cfg_q.valid_min_mm <= pwdata[tgr_pkg::DIST_W-1:0];
				tgr_pkg::REG_VALID_MAX: cfg_q.valid_max_mm <= pwdata[tgr_pkg::DIST_W-1:0];
				tgr_pkg::REG_ENTER: cfg_q.enter_mm <= pwdata[tgr_pkg::DIST_W-1:0];
				tgr_pkg::REG_LEAVE: cfg_q.leave_mm <= pwdata[tgr_pkg::DIST_W-1:0];
				tgr_pkg::REG_WAVE_MIN: cfg_q.wave_min_ms <= pwdata[tgr_pkg::MS_W-1:0];
				tgr_pkg::REG_WAVE_MAX: cfg_q.wave_max_ms <= pwdata[tgr_pkg::MS_W-1:0];
				tgr_pkg::REG_HOLD: cfg_q.hold_ms <= pwdata[tgr_pkg::MS_W-1:0];
				tgr_pkg::REG_DOUBLE: cfg_q.double_ms <= pwdata[tgr_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the stored value, zero-extended to the bus width.
	always_comb begin
		case (reg_idx)
			tgr_pkg::REG_VALID_MIN: prdata = {{DPAD{1'b0}}, cfg_q.valid_min_mm};
			tgr_pkg::REG_VALID_MAX: prdata = {{DPAD{1'b0}}, cfg_q.valid_max_mm};
			tgr_pkg::REG_ENTER: prdata = {{DPAD{1'b0}}, cfg_q.enter_mm};
			tgr_pkg::REG_LEAVE: prdata = {{DPAD{1'b0}}, cfg_q.leave_mm};
			tgr_pkg::REG_WAVE_MIN: prdata = {{MPAD{1'b0}}, cfg_q.wave_min_ms};
			tgr_pkg::REG_WAVE_MAX: prdata = {{MPAD{1'b0}}, cfg_q.wave_max_ms};
			tgr_pkg::REG_HOLD: prdata = {{MPAD{1'b0}}, cfg_q.hold_ms};
			tgr_pkg::REG_DOUBLE: prdata = {{MPAD{1'b0}}, cfg_q.double_ms};
			default: prdata = '0;
		endcase
	end

	// The front end judges each sample and updates the filter as it is accepted.
	tgr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.q_full(qstat.full),
		.distance_mm(distance_mm),
		.now_ms(now_ms),
		.q_wr(q_wr),
		.q_item(front_item)
	);

	// The queue lets sample intake continue while results wait to be popped.
	tgr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wr_item(front_item),
		.rd(q_rd),
		.rd_item(head_item),
		.stat(qstat)
	);

	// The back end runs the gesture machine and holds the result for the consumer.
	tgr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(head_item),
		.qstat(qstat),
		.q_rd(q_rd),
		.pop(pop),
		.out_valid(out_valid),
		.gesture_event(gesture_event),
		.smoothed_mm(smoothed_mm),
		.hand_near(hand_near)
	);

	assign full = qstat.full;
	assign empty = ~out_valid;

	// The queue can never report full and empty together.
	assert property (@(posedge clk) disable iff (!arst_n) !(qstat.full && qstat.empty))
		else $error("queue reports full and empty at once");

	// An accepted request is always in the queue at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n) (push && !full) |=> !qstat.empty)
		else $error("accepted request missing from queue");

	// Near and holding events only come with the hand reported close.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (gesture_event == tgr_pkg::EV_NEAR || gesture_event == tgr_pkg::EV_HOLDING
			|| gesture_event == tgr_pkg::EV_HOLD_START)) |-> hand_near)
		else $error("near-type event without hand_near");

	// Events that leave the near region always clear hand_near.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (gesture_event == tgr_pkg::EV_FAR || gesture_event == tgr_pkg::EV_WAVE
			|| gesture_event == tgr_pkg::EV_DOUBLE || gesture_event == tgr_pkg::EV_HOLD_END))
			|-> !hand_near)
		else $error("leave event with hand_near set");

endmodule
`default_nettype wire

// ===== tb/tb_tof_gesture_recognizer_unit.sv =====
// Self-checking testbench for the time-of-flight gesture recognizer unit.
`default_nettype none
module tb_tof_gesture_recognizer_unit;

	// A stall or idle stretch longer than this many cycles without any
	// accepted request, result or register write means the unit has hung.
	localparam int QUIET_LIMIT = 2000;
	// Length of the deliberate receiver hold-off that fills the unit up.
	localparam int HOLD_OFF_CYCLES = 80;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_NEAR = 2'd1,
		PH_HOLD = 2'd2
	} hand_phase_t;

	// One predicted result, laid out like the result ports.
	typedef struct packed {
		tgr_pkg::event_t ev;
		logic [tgr_pkg::DIST_W-1:0] mm;
		logic near;
	} gesture_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [tgr_pkg::ADDR_W-1:0] paddr = '0;
	logic [tgr_pkg::DATA_W-1:0] pwdata = '0;
	logic [tgr_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [tgr_pkg::DIST_W-1:0] distance_mm = '0;
	logic [tgr_pkg::TIME_W-1:0] now_ms = '0;
	logic empty;
	logic pop = 1'b0;
	logic [2:0] gesture_event;
	logic [tgr_pkg::DIST_W-1:0] smoothed_mm;
	logic hand_near;

	tof_gesture_recognizer_unit dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the register file and of the gesture state. The register
	// copy is updated at the edge that writes the hardware register, and the
	// gesture state at the edge that accepts each request, so the prediction
	// always sees exactly what the unit sees.
	tgr_pkg::cfg_t gcfg = '{
		valid_min_mm: tgr_pkg::RST_VALID_MIN,
		valid_max_mm: tgr_pkg::RST_VALID_MAX,
		enter_mm: tgr_pkg::RST_ENTER,
		leave_mm: tgr_pkg::RST_LEAVE,
		wave_min_ms: tgr_pkg::RST_WAVE_MIN,
		wave_max_ms: tgr_pkg::RST_WAVE_MAX,
		hold_ms: tgr_pkg::RST_HOLD,
		double_ms: tgr_pkg::RST_DOUBLE
	};
	hand_phase_t hand_phase = PH_IDLE;
	logic [tgr_pkg::DIST_W-1:0] filt_mm = tgr_pkg::FILT_EMPTY;
	logic [tgr_pkg::TIME_W-1:0] near_start_ms = '0;
	logic [tgr_pkg::TIME_W-1:0] last_wave_ms = '0;
	logic hold_flag = 1'b0;

	// Results still owed by the unit, oldest first.
	gesture_result_t pending_results[$];

	int mismatch_count = 0;
	int samples_sent = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	int pop_stall_pct = 0;
	logic pressure_req = 1'b0;
	logic hold_off = 1'b0;
	// Running timestamp that the gesture generators advance.
	logic [tgr_pkg::TIME_W-1:0] clock_ms = '0;

	// Predicts the result of one sample and advances the shadow state.
	function automatic gesture_result_t classify_sample(
			input logic [tgr_pkg::DIST_W-1:0] sample_mm,
			input logic [tgr_pkg::TIME_W-1:0] stamp);
		gesture_result_t res;
		logic [tgr_pkg::JDG_W-1:0] judged;
		logic [tgr_pkg::TIME_W-1:0] held;
		logic [tgr_pkg::TIME_W-1:0] since_wave;
		res.ev = tgr_pkg::EV_NONE;
		// A valid sample feeds the filter; the first one (or one after the
		// filter happens to hold the empty mark) loads it directly. An invalid
		// sample is judged one past the valid window, at full width.
		if (sample_mm >= gcfg.valid_min_mm && sample_mm <= gcfg.valid_max_mm) begin
			if (filt_mm == tgr_pkg::FILT_EMPTY) begin
				filt_mm = sample_mm;
			end else begin
				filt_mm = tgr_pkg::DIST_W'((3 * int'(filt_mm) + int'(sample_mm)) / 4);
			end
			judged = {1'b0, filt_mm};
		end else begin
			judged = {1'b0, gcfg.valid_max_mm} + 1'b1;
		end
		// Time differences wrap modulo the timestamp width.
		held = stamp - near_start_ms;
		since_wave = stamp - last_wave_ms;
		case (hand_phase)
			PH_IDLE: begin
				if (judged < {1'b0, gcfg.enter_mm}) begin
					hand_phase = PH_NEAR;
					near_start_ms = stamp;
					hold_flag = 1'b0;
					res.ev = tgr_pkg::EV_NEAR;
				end
			end
			PH_NEAR: begin
				if (judged > {1'b0, gcfg.leave_mm}) begin
					hand_phase = PH_IDLE;
					if (held >= gcfg.wave_min_ms && held <= gcfg.wave_max_ms) begin
						// A wave close behind the previous one pairs with it and
						// clears the wave time, so a third wave starts afresh.
						if (since_wave <= gcfg.double_ms) begin
							last_wave_ms = '0;
							res.ev = tgr_pkg::EV_DOUBLE;
						end else begin
							last_wave_ms = stamp;
							res.ev = tgr_pkg::EV_WAVE;
						end
					end else begin
						res.ev = tgr_pkg::EV_FAR;
					end
				end else if (held >= gcfg.hold_ms) begin
					hand_phase = PH_HOLD;
					hold_flag = 1'b1;
					res.ev = tgr_pkg::EV_HOLD_START;
				end
			end
			PH_HOLD: begin
				if (judged > {1'b0, gcfg.leave_mm}) begin
					hand_phase = PH_IDLE;
					hold_flag = 1'b0;
					res.ev = tgr_pkg::EV_HOLD_END;
				end else if (hold_flag) begin
					res.ev = tgr_pkg::EV_HOLDING;
				end
			end
			default: begin
				hand_phase = PH_IDLE;
			end
		endcase
		res.mm = filt_mm;
		res.near = (hand_phase == PH_NEAR || hand_phase == PH_HOLD);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Offers one request and returns at the edge that accepts it. push is left
	// high so that back-to-back requests follow without a gap; whoever stops
	// sending lowers it at the next falling edge.
	task automatic send_sample(input logic [tgr_pkg::DIST_W-1:0] sample_mm,
			input logic [tgr_pkg::TIME_W-1:0] stamp);
		@(negedge clk);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		distance_mm <= sample_mm;
		now_ms <= stamp;
		do @(posedge clk); while (full);
		pending_results.push_back(classify_sample(sample_mm, stamp));
		samples_sent++;
	endtask

	// Two-phase register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
			input logic [tgr_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			tgr_pkg::REG_VALID_MIN: gcfg.valid_min_mm = value[tgr_pkg::DIST_W-1:0];
			tgr_pkg::REG_VALID_MAX: gcfg.valid_max_mm = value[tgr_pkg::DIST_W-1:0];
			tgr_pkg::REG_ENTER: gcfg.enter_mm = value[tgr_pkg::DIST_W-1:0];
			tgr_pkg::REG_LEAVE: gcfg.leave_mm = value[tgr_pkg::DIST_W-1:0];
			tgr_pkg::REG_WAVE_MIN: gcfg.wave_min_ms = value[tgr_pkg::MS_W-1:0];
			tgr_pkg::REG_WAVE_MAX: gcfg.wave_max_ms = value[tgr_pkg::MS_W-1:0];
			tgr_pkg::REG_HOLD: gcfg.hold_ms = value[tgr_pkg::MS_W-1:0];
			default: gcfg.double_ms = value[tgr_pkg::MS_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stops sending and waits until every owed result has come out, then idles
	// before returning, so registers can be rewritten safely.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Sends close samples until the shadow machine leaves idle, giving up after 16 tries.
	task automatic approach_hand(input int step_max);
		int tries = 0;
		while (hand_phase == PH_IDLE && tries < 16) begin
			clock_ms += $urandom_range(step_max, 0);
			send_sample(gcfg.valid_min_mm + tgr_pkg::DIST_W'($urandom_range(3, 0)), clock_ms);
			tries++;
		end
	endtask

	// One hand movement: approach, stay close for a chosen time, withdraw.
	// The dwell is aimed below or inside the wave window, past the hold time, or
	// anywhere up to 2000 ms, so every outcome of the machine comes up regularly.
	task automatic play_gesture();
		logic [tgr_pkg::TIME_W-1:0] t0;
		logic [tgr_pkg::DIST_W-1:0] far_mm;
		int dwell;
		int steps;
		int tries;
		approach_hand(20);
		if (hand_phase == PH_IDLE) begin
			return;
		end
		t0 = clock_ms;
		case ($urandom_range(3, 0))
			0: dwell = $urandom_range(gcfg.wave_min_ms, 0);
			1: dwell = $urandom_range(gcfg.wave_max_ms, gcfg.wave_min_ms);
			2: dwell = $urandom_range(int'(gcfg.hold_ms) + 800, gcfg.hold_ms);
			default: dwell = $urandom_range(2000, 0);
		endcase
		steps = $urandom_range(4, 0);
		for (int k = 1; k <= steps; k++) begin
			clock_ms = t0 + tgr_pkg::TIME_W'(dwell * k / (steps + 1));
			send_sample(gcfg.valid_min_mm + tgr_pkg::DIST_W'($urandom_range(
					int'(gcfg.enter_mm) - int'(gcfg.valid_min_mm) - 1, 0)), clock_ms);
		end
		clock_ms = t0 + tgr_pkg::TIME_W'(dwell);
		if ($urandom_range(1, 0)) begin
			// Withdraw at once through an out-of-window sample.
			if ($urandom_range(1, 0) && gcfg.valid_min_mm != 0) begin
				far_mm = tgr_pkg::DIST_W'($urandom_range(int'(gcfg.valid_min_mm) - 1, 0));
			end else begin
				far_mm = tgr_pkg::DIST_W'($urandom_range(8191, int'(gcfg.valid_max_mm) + 1));
			end
			send_sample(far_mm, clock_ms);
		end else begin
			// Withdraw slowly: the filter has to climb past the leave level.
			tries = 0;
			while (hand_phase != PH_IDLE && tries < 12) begin
				send_sample(tgr_pkg::DIST_W'($urandom_range(gcfg.valid_max_mm,
						int'(gcfg.leave_mm) + 1)), clock_ms);
				clock_ms += $urandom_range(5, 0);
				tries++;
			end
			if (hand_phase != PH_IDLE) begin
				send_sample(tgr_pkg::DIST_W'(8191), clock_ms);
			end
		end
		// Gaps around the double-wave window pair some waves up.
		clock_ms += $urandom_range(2 * int'(gcfg.double_ms) + 100, 0);
	endtask

	// Window settings that keep valid_min < enter <= leave <= valid_max, so
	// that the gesture generator can reach every phase.
	task automatic random_config();
		int vmin;
		int enter;
		int wmin;
		vmin = $urandom_range(120, 0);
		enter = $urandom_range(400, vmin + 20);
		wmin = $urandom_range(150, 0);
		write_reg(tgr_pkg::REG_VALID_MIN, vmin);
		write_reg(tgr_pkg::REG_VALID_MAX, $urandom_range(8189, 700));
		write_reg(tgr_pkg::REG_ENTER, enter);
		write_reg(tgr_pkg::REG_LEAVE, $urandom_range(enter + 300, enter));
		write_reg(tgr_pkg::REG_WAVE_MIN, wmin);
		write_reg(tgr_pkg::REG_WAVE_MAX, $urandom_range(wmin + 900, wmin));
		write_reg(tgr_pkg::REG_HOLD, $urandom_range(1500, 100));
		write_reg(tgr_pkg::REG_DOUBLE, $urandom_range(1200, 0));
	endtask

	// The filter holds its empty mark from reset until the first valid sample, so
	// this runs straight after reset. It also covers the judged distance of an
	// invalid sample at the top of the range and an inverted valid window.
	task automatic test_sentinel_and_judging();
		// A valid sample equal to the empty mark leaves the filter looking
		// unloaded, so the next valid sample is loaded directly.
		write_reg(tgr_pkg::REG_VALID_MIN, 0);
		write_reg(tgr_pkg::REG_VALID_MAX, 8190);
		send_sample(13'd8190, 32'd5);
		send_sample(13'd100, 32'd10);
		send_sample(13'd8190, 32'd20);
		settle();
		// With valid_max at the top, an invalid sample is judged as 8192 and
		// still counts as beyond the highest leave level.
		write_reg(tgr_pkg::REG_VALID_MAX, 8191);
		write_reg(tgr_pkg::REG_VALID_MIN, 200);
		write_reg(tgr_pkg::REG_ENTER, 8191);
		write_reg(tgr_pkg::REG_LEAVE, 8191);
		send_sample(13'd200, 32'd30);
		send_sample(13'd0, 32'd40);
		settle();
		write_reg(tgr_pkg::REG_VALID_MAX, 8189);
		write_reg(tgr_pkg::REG_LEAVE, 8189);
		send_sample(13'd8191, 32'd50);
		send_sample(13'd8191, 32'd60);
		settle();
		// Inverted valid window: every sample is invalid.
		write_reg(tgr_pkg::REG_VALID_MIN, 1000);
		write_reg(tgr_pkg::REG_VALID_MAX, 10);
		send_sample(13'd500, 32'd70);
		send_sample(13'd5, 32'd80);
		send_sample(13'd8191, 32'd90);
	endtask

	// Reset settings, one of each gesture, field extremes and a timestamp wrap.
	task automatic test_directed_gestures();
		settle();
		write_reg(tgr_pkg::REG_VALID_MIN, tgr_pkg::RST_VALID_MIN);
		write_reg(tgr_pkg::REG_VALID_MAX, tgr_pkg::RST_VALID_MAX);
		write_reg(tgr_pkg::REG_ENTER, tgr_pkg::RST_ENTER);
		write_reg(tgr_pkg::REG_LEAVE, tgr_pkg::RST_LEAVE);
		write_reg(tgr_pkg::REG_WAVE_MIN, tgr_pkg::RST_WAVE_MIN);
		write_reg(tgr_pkg::REG_WAVE_MAX, tgr_pkg::RST_WAVE_MAX);
		write_reg(tgr_pkg::REG_HOLD, tgr_pkg::RST_HOLD);
		write_reg(tgr_pkg::REG_DOUBLE, tgr_pkg::RST_DOUBLE);
		send_sample(13'd0, 32'd0);
		clock_ms = 32'd100;
		approach_hand(0);
		// No wave has happened yet and the wave time is still zero, so the
		// first wave this early counts as a double wave.
		send_sample(13'd8191, 32'd300);
		send_sample(13'd40, 32'd1000);
		send_sample(13'd8191, 32'd1300);
		send_sample(13'd40, 32'd1500);
		send_sample(13'd8191, 32'd1700);
		send_sample(13'd40, 32'd2000);
		send_sample(13'd8191, 32'd2030);
		send_sample(13'd40, 32'd3000);
		send_sample(13'd40, 32'd3100);
		send_sample(13'd40, 32'd3750);
		send_sample(13'd40, 32'd3800);
		send_sample(13'd8191, 32'd4000);
		// Near time measured across the timestamp wrap.
		send_sample(13'd40, 32'hFFFF_FF00);
		send_sample(13'd8191, 32'h0000_0020);
		send_sample(13'd1200, 32'd4100);
		send_sample(13'd39, 32'd4200);
		send_sample(13'd1201, 32'd4300);
		send_sample(13'd8191, 32'hFFFF_FFFF);
	endtask

	// Extremes of the time registers and of the enter level.
	task automatic test_timing_windows();
		settle();
		write_reg(tgr_pkg::REG_VALID_MIN, tgr_pkg::RST_VALID_MIN);
		write_reg(tgr_pkg::REG_VALID_MAX, tgr_pkg::RST_VALID_MAX);
		write_reg(tgr_pkg::REG_ENTER, tgr_pkg::RST_ENTER);
		write_reg(tgr_pkg::REG_LEAVE, tgr_pkg::RST_LEAVE);
		write_reg(tgr_pkg::REG_HOLD, tgr_pkg::RST_HOLD);
		write_reg(tgr_pkg::REG_DOUBLE, tgr_pkg::RST_DOUBLE);
		// Inverted wave window: no dwell is ever a wave.
		write_reg(tgr_pkg::REG_WAVE_MIN, 600);
		write_reg(tgr_pkg::REG_WAVE_MAX, 100);
		clock_ms = 32'd10000;
		approach_hand(0);
		clock_ms += 300;
		send_sample(13'd8191, clock_ms);
		settle();
		write_reg(tgr_pkg::REG_WAVE_MIN, 0);
		write_reg(tgr_pkg::REG_WAVE_MAX, 16'hFFFF);
		write_reg(tgr_pkg::REG_HOLD, 16'hFFFF);
		write_reg(tgr_pkg::REG_DOUBLE, 0);
		approach_hand(0);
		clock_ms += 40000;
		send_sample(13'd8191, clock_ms);
		// Zero near time and zero gap since the last wave.
		approach_hand(0);
		send_sample(13'd8191, clock_ms);
		settle();
		write_reg(tgr_pkg::REG_HOLD, 0);
		write_reg(tgr_pkg::REG_DOUBLE, 16'hFFFF);
		approach_hand(0);
		clock_ms += 5;
		send_sample(13'd40, clock_ms);
		clock_ms += 5;
		send_sample(13'd40, clock_ms);
		send_sample(13'd8191, clock_ms);
		approach_hand(0);
		clock_ms += 1000;
		send_sample(13'd8191, clock_ms);
		settle();
		// An enter level of zero keeps the machine idle.
		write_reg(tgr_pkg::REG_ENTER, 0);
		send_sample(13'd40, clock_ms);
	endtask

	task automatic test_random_gestures(input int idle_pct, input int stall_pct,
			input int how_many);
		int stop_at;
		sender_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		settle();
		random_config();
		stop_at = samples_sent + how_many;
		while (samples_sent < stop_at) begin
			if ($urandom_range(7, 0) == 0) begin
				// Noise: arbitrary distances, sometimes arbitrary timestamps.
				repeat ($urandom_range(4, 1)) begin
					send_sample(tgr_pkg::DIST_W'($urandom),
							$urandom_range(1, 0) ? tgr_pkg::TIME_W'($urandom) : clock_ms);
				end
			end else begin
				play_gesture();
			end
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the input queue fills and full must throttle the sender.
	task automatic test_input_backpressure();
		int stop_at;
		sender_idle_pct = 0;
		pop_stall_pct = 0;
		pressure_req = 1'b1;
		stop_at = samples_sent + 30;
		while (samples_sent < stop_at) begin
			play_gesture();
		end
	endtask

	// Receiver side: pop is redrawn every falling edge, forced low during a
	// deliberate hold-off.
	always @(negedge clk) begin
		pop <= !hold_off && ($urandom_range(99, 0) >= pop_stall_pct);
	end

	// The hold-off is counted here, on rising edges, apart from the sender.
	always begin
		@(posedge clk);
		if (pressure_req) begin
			pressure_req = 1'b0;
			hold_off = 1'b1;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			hold_off = 1'b0;
		end
	end

	// Every result taken by the receiver is compared with the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		gesture_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, event %0d", gesture_event));
			end else begin
				want = pending_results.pop_front();
				if (gesture_event !== want.ev) begin
					report_mismatch($sformatf("gesture_event %0d, expected %0d",
							gesture_event, want.ev));
				end
				if (smoothed_mm !== want.mm) begin
					report_mismatch($sformatf("smoothed_mm %0d, expected %0d",
							smoothed_mm, want.mm));
				end
				if (hand_near !== want.near) begin
					report_mismatch($sformatf("hand_near %0b, expected %0b",
							hand_near, want.near));
				end
			end
		end
	end

	// Watchdog: counts cycles in which nothing at all is accepted.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_tof_gesture_recognizer_unit: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_sentinel_and_judging();
		test_directed_gestures();
		test_timing_windows();
		test_random_gestures(0, 0, 240);
		test_random_gestures(58, 0, 240);
		test_random_gestures(0, 58, 240);
		test_input_backpressure();
		test_random_gestures(20, 20, 240);
		settle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_tof_gesture_recognizer_unit: PASS");
		end else begin
			$display("tb_tof_gesture_recognizer_unit: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== tof_gesture_recognizer_unit.f =====
sv/tgr_pkg.sv
sv/tgr_front.sv
sv/tgr_fifo.sv
sv/tgr_back.sv
sv/tof_gesture_recognizer_unit.sv
tb/tb_tof_gesture_recognizer_unit.sv
